// ===== sv/nfbs_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the buffer selector.
package nfbs_pkg;

  // Default number of capture buffers.
  localparam int NUM_BUFFERS_DEFAULT = 4;

  // Buffers that have a frame number input.
  localparam int NUM_FRAME_INPUTS = 4;

  // Field widths.
  localparam int FRAME_W    = 8;
  localparam int OUTCOME_W  = 3;
  localparam int SLOT_OUT_W = 2;

  // Frame numbers wrap modulo this value. A later frame leads by at most AHEAD_MAX.
  localparam logic [FRAME_W-1:0] SEQ_MOD   = 8'd255;
  localparam logic [FRAME_W-1:0] AHEAD_MAX = 8'd127;

  // Request operation codes.
  typedef enum logic {
    OP_SCAN    = 1'b0,
    OP_OUTCOME = 1'b1
  } op_t;

  // Result outcome codes.
  typedef enum logic [OUTCOME_W-1:0] {
    OC_CHOSEN     = 3'd0,
    OC_NONE_READY = 3'd1,
    OC_DELIVERED  = 3'd2,
    OC_OVERWRITE  = 3'd3,
    OC_COPY_FAULT = 3'd4,
    OC_NO_PENDING = 3'd5
  } outcome_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_scan;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

// ===== sv/nfbs_ctrl.sv =====
// Controller state machine: accepts a request, sequences the scan and hands off the result.
module nfbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  nfbs_pkg::status_t status,
  output nfbs_pkg::cmd_t    cmd
);

  nfbs_pkg::state_t state;
  nfbs_pkg::state_t state_next;
  logic             accept;

  // A new request is taken only in the idle state.
  assign in_stall = rst || (state != nfbs_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nfbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      nfbs_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = status.op_scan ? nfbs_pkg::ST_SCAN : nfbs_pkg::ST_RESULT;
        end
      end
      nfbs_pkg::ST_SCAN: begin
        if (status.scan_last) begin
          state_next = nfbs_pkg::ST_RESULT;
        end
      end
      nfbs_pkg::ST_RESULT: begin
        if (status.out_free) begin
          state_next = nfbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nfbs_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    case (state)
      nfbs_pkg::ST_IDLE: begin
        cmd.capture = accept;
      end
      nfbs_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      nfbs_pkg::ST_RESULT: begin
        cmd.commit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== sv/nfbs_dp.sv =====
// Datapath: captured request, rotating scan unit, pending choice, delivery history and output register.
module nfbs_dp #(
  parameter int NUM_BUFFERS = nfbs_pkg::NUM_BUFFERS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  nfbs_pkg::cmd_t                      cmd,
  output nfbs_pkg::status_t                   status,
  // Request fields.
  input  logic                                operation,
  input  logic [nfbs_pkg::FRAME_W-1:0]        frame_number_0,
  input  logic [nfbs_pkg::FRAME_W-1:0]        frame_number_1,
  input  logic [nfbs_pkg::FRAME_W-1:0]        frame_number_2,
  input  logic [nfbs_pkg::FRAME_W-1:0]        frame_number_3,
  input  logic [nfbs_pkg::FRAME_W-1:0]        recheck_number,
  input  logic                                copy_done,
  // Configuration.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                prefer_newest,
  // Result.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [nfbs_pkg::OUTCOME_W-1:0]      outcome,
  output logic [nfbs_pkg::SLOT_OUT_W-1:0]     chosen_slot,
  output logic [nfbs_pkg::FRAME_W-1:0]        chosen_number
);

  localparam int SLOT_W = $clog2(NUM_BUFFERS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_BUFFERS - 1);

  // Configuration register.
  logic                            newest_mode;

  // Captured request.
  logic [nfbs_pkg::FRAME_W-1:0]    nums [NUM_BUFFERS];
  logic [nfbs_pkg::FRAME_W-1:0]    frame_in [nfbs_pkg::NUM_FRAME_INPUTS];
  logic                            op_scan_reg;
  logic [nfbs_pkg::FRAME_W-1:0]    recheck;
  logic                            copy_ok;

  // Scan unit.
  logic [SLOT_W-1:0]               ptr;
  logic [SLOT_W-1:0]               step_count;
  logic                            found;
  logic [SLOT_W-1:0]               sel;
  logic [nfbs_pkg::FRAME_W-1:0]    best;

  // Persistent state.
  logic [nfbs_pkg::FRAME_W-1:0]    last_delivered [NUM_BUFFERS];
  logic [SLOT_W-1:0]               scan_start;
  logic [SLOT_W-1:0]               pending_slot;
  logic [nfbs_pkg::FRAME_W-1:0]    pending_number;
  logic                            pending_valid;

  // Output register.
  logic                            result_valid;
  nfbs_pkg::outcome_t              result_code;
  logic [SLOT_W-1:0]               result_slot;
  logic [nfbs_pkg::FRAME_W-1:0]    result_number;

  // Scan step signals.
  logic [nfbs_pkg::FRAME_W-1:0]    cand_num;
  logic                            cand_ok;
  logic [nfbs_pkg::FRAME_W-1:0]    raw_diff;
  logic [nfbs_pkg::FRAME_W-1:0]    seq_delta;
  logic                            is_ahead;
  logic                            take;
  logic [SLOT_W-1:0]               ptr_wrap;

  // Commit signals.
  nfbs_pkg::outcome_t              commit_code;
  logic [SLOT_W-1:0]               commit_slot;
  logic [nfbs_pkg::FRAME_W-1:0]    commit_number;
  logic [SLOT_W-1:0]               start_after;

  assign frame_in[0] = frame_number_0;
  assign frame_in[1] = frame_number_1;
  assign frame_in[2] = frame_number_2;
  assign frame_in[3] = frame_number_3;

  assign cfg_ready = 1'b1;

  // Configuration register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      newest_mode <= 1'b1;
    end else if (cfg_valid) begin
      newest_mode <= prefer_newest;
    end
  end

  // Capture the request; buffers beyond the input fields read as incomplete.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_scan_reg <= (operation == nfbs_pkg::OP_SCAN);
      recheck     <= recheck_number;
      copy_ok     <= copy_done;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        if (i < nfbs_pkg::NUM_FRAME_INPUTS) begin
          nums[i] <= frame_in[i];
        end else begin
          nums[i] <= '0;
        end
      end
    end
  end

  // Candidate test and sequence distance modulo 255 for the slot under the pointer.
  always_comb begin
    cand_num = nums[ptr];
    cand_ok  = (cand_num != '0) && (cand_num != last_delivered[ptr]);
    raw_diff = cand_num - best;
    if (cand_num >= best) begin
      seq_delta = (raw_diff == nfbs_pkg::SEQ_MOD) ? '0 : raw_diff;
    end else begin
      seq_delta = raw_diff - 8'd1;
    end
    is_ahead = (seq_delta != '0) && (seq_delta <= nfbs_pkg::AHEAD_MAX);
    take     = cand_ok && (!found || (newest_mode && is_ahead));
    ptr_wrap = (ptr == LAST_SLOT) ? '0 : ptr + 1'b1;
  end

  // Scan unit: one slot per cycle in rotation from the start pointer.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ptr        <= scan_start;
      step_count <= '0;
      found      <= 1'b0;
      sel        <= '0;
      best       <= '0;
    end else if (cmd.scan_step) begin
      ptr        <= ptr_wrap;
      step_count <= step_count + 1'b1;
      if (take) begin
        found <= 1'b1;
        sel   <= ptr;
        best  <= cand_num;
      end
    end
  end

  // Result of the finished request.
  always_comb begin
    start_after = (pending_slot == LAST_SLOT) ? '0 : pending_slot + 1'b1;
    if (op_scan_reg) begin
      commit_code   = found ? nfbs_pkg::OC_CHOSEN : nfbs_pkg::OC_NONE_READY;
      commit_slot   = found ? sel : '0;
      commit_number = found ? best : '0;
    end else if (!pending_valid) begin
      commit_code   = nfbs_pkg::OC_NO_PENDING;
      commit_slot   = '0;
      commit_number = '0;
    end else begin
      commit_slot   = pending_slot;
      commit_number = pending_number;
      if (recheck != pending_number) begin
        commit_code = nfbs_pkg::OC_OVERWRITE;
      end else if (!copy_ok) begin
        commit_code = nfbs_pkg::OC_COPY_FAULT;
      end else begin
        commit_code = nfbs_pkg::OC_DELIVERED;
      end
    end
  end

  // Pending choice, delivery history and scan start.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid  <= 1'b0;
      pending_slot   <= '0;
      pending_number <= '0;
      scan_start     <= '0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        last_delivered[i] <= '0;
      end
    end else if (cmd.commit) begin
      if (op_scan_reg) begin
        pending_valid  <= found;
        pending_slot   <= sel;
        pending_number <= best;
      end else begin
        pending_valid <= 1'b0;
        if (commit_code == nfbs_pkg::OC_DELIVERED) begin
          last_delivered[pending_slot] <= pending_number;
          scan_start                   <= start_after;
        end
      end
    end
  end

  // Output register; holds while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!out_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result_code   <= commit_code;
      result_slot   <= commit_slot;
      result_number <= commit_number;
    end
  end

  assign out_valid     = result_valid;
  assign outcome       = result_code;
  assign chosen_slot   = nfbs_pkg::SLOT_OUT_W'(result_slot);
  assign chosen_number = result_number;

  // Status to the controller.
  assign status.op_scan   = (operation == nfbs_pkg::OP_SCAN);
  assign status.scan_last = (step_count == LAST_SLOT);
  assign status.out_free  = !result_valid || !out_stall;

endmodule

// ===== sv/newest_frame_buffer_selector.sv =====
// Top level of the newest frame buffer selector: controller plus datapath.
//
//   channel   signals                      handshake
//   --------  ---------------------------  -----------------------------
//   request   operation, frame_number_0-3,  in_valid / in_stall
//             recheck_number, copy_done
//   result    outcome, chosen_slot,        out_valid / out_stall
//             chosen_number
//   config    prefer_newest                cfg_valid / cfg_ready (always 1)
//
// One request is worked at a time. A scan request passes through the scan state, where
// one slot is examined per cycle by the scan unit, and then the result state.
// An outcome request goes straight to the result state. A result waits in the output
// register while out_stall is high; the block then holds the next request off until it
// can commit. Reset (rst, synchronous) clears the delivery history, scan start, pending
// choice and sets prefer_newest to 1; no clearing pass is needed.
module newest_frame_buffer_selector #(
  parameter int NUM_BUFFERS = nfbs_pkg::NUM_BUFFERS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Request channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              operation,
  input  logic [nfbs_pkg::FRAME_W-1:0]      frame_number_0,
  input  logic [nfbs_pkg::FRAME_W-1:0]      frame_number_1,
  input  logic [nfbs_pkg::FRAME_W-1:0]      frame_number_2,
  input  logic [nfbs_pkg::FRAME_W-1:0]      frame_number_3,
  input  logic [nfbs_pkg::FRAME_W-1:0]      recheck_number,
  input  logic                              copy_done,
  // Configuration channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              prefer_newest,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nfbs_pkg::OUTCOME_W-1:0]    outcome,
  output logic [nfbs_pkg::SLOT_OUT_W-1:0]   chosen_slot,
  output logic [nfbs_pkg::FRAME_W-1:0]      chosen_number
);

  nfbs_pkg::cmd_t    cmd;
  nfbs_pkg::status_t status;

  // Sequencing.
  nfbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage and selection logic.
  nfbs_dp #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .operation      (operation),
    .frame_number_0 (frame_number_0),
    .frame_number_1 (frame_number_1),
    .frame_number_2 (frame_number_2),
    .frame_number_3 (frame_number_3),
    .recheck_number (recheck_number),
    .copy_done      (copy_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .prefer_newest  (prefer_newest),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .outcome        (outcome),
    .chosen_slot    (chosen_slot),
    .chosen_number  (chosen_number)
  );

endmodule

// ===== sv/nfbs_check.sv =====
// Port-level checker for the buffer selector and its bind to the top level.
module nfbs_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [nfbs_pkg::OUTCOME_W-1:0]    outcome,
  input logic [nfbs_pkg::SLOT_OUT_W-1:0]   chosen_slot,
  input logic [nfbs_pkg::FRAME_W-1:0]      chosen_number
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(outcome) && $stable(chosen_slot)
      && $stable(chosen_number))
    else $error("stalled result changed");

  // Requests are worked one at a time, so an accepted request blocks the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  // Outcomes without a buffer carry a zero slot and number.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == nfbs_pkg::OC_NONE_READY || outcome == nfbs_pkg::OC_NO_PENDING)
      |-> chosen_slot == '0 && chosen_number == '0)
    else $error("empty outcome with slot or number set");

  // A chosen or delivered buffer never has an incomplete frame number.
  a_nonzero_choice: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == nfbs_pkg::OC_CHOSEN || outcome == nfbs_pkg::OC_DELIVERED)
      |-> chosen_number != '0)
    else $error("chosen buffer has frame number zero");

endmodule

bind newest_frame_buffer_selector nfbs_check u_nfbs_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .outcome       (outcome),
  .chosen_slot   (chosen_slot),
  .chosen_number (chosen_number)
);

// ===== verif/frame_selector_checker.sv =====
// Checker that predicts each result of the frame buffer selector and compares it with the block.
`timescale 1ns / 1ps
module frame_selector_checker #(
  parameter int NUM_BUFFERS = nfbs_pkg::NUM_BUFFERS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            operation,
  input  logic [nfbs_pkg::FRAME_W-1:0]    frame_number_0,
  input  logic [nfbs_pkg::FRAME_W-1:0]    frame_number_1,
  input  logic [nfbs_pkg::FRAME_W-1:0]    frame_number_2,
  input  logic [nfbs_pkg::FRAME_W-1:0]    frame_number_3,
  input  logic [nfbs_pkg::FRAME_W-1:0]    recheck_number,
  input  logic                            copy_done,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic                            prefer_newest,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [nfbs_pkg::OUTCOME_W-1:0]  outcome,
  input  logic [nfbs_pkg::SLOT_OUT_W-1:0] chosen_slot,
  input  logic [nfbs_pkg::FRAME_W-1:0]    chosen_number,
  output int                              mismatch_count,
  output int                              open_count,
  output logic [nfbs_pkg::FRAME_W-1:0]    held_number
);
  import nfbs_pkg::*;

  typedef struct packed {
    logic [OUTCOME_W-1:0]  code;
    logic [SLOT_OUT_W-1:0] slot;
    logic [FRAME_W-1:0]    number;
  } selection_t;

  // Predicted selector state.
  logic [FRAME_W-1:0] delivered_num [NUM_BUFFERS];
  int unsigned        start_slot;
  int unsigned        held_slot;
  logic [FRAME_W-1:0] held_num;
  logic               held_ok;
  logic               newest_mode;

  selection_t         expected_q [$];
  int                 errors = 0;

  assign mismatch_count = errors;

  // Counts a failure and reports the first few of them.
  task automatic flag(string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Works out the result of one request and advances the predicted state.
  function automatic selection_t select_or_settle(
    logic                                     op,
    logic [NUM_FRAME_INPUTS-1:0][FRAME_W-1:0] frames,
    logic [FRAME_W-1:0]                       recheck,
    logic                                     done
  );
    selection_t  r;
    logic        found;
    int unsigned pick;
    int unsigned best;
    int unsigned v;
    int unsigned lead;
    int unsigned slot;
    int          i;
    r.code   = OC_NO_PENDING;
    r.slot   = '0;
    r.number = '0;
    if (op == OP_SCAN) begin
      found = 1'b0;
      pick  = 0;
      best  = 0;
      // Visit the buffers in rotation; in newest mode a newer frame within half the sequence range wins.
      for (i = 0; i < NUM_BUFFERS; i++) begin
        slot = (start_slot + i) % NUM_BUFFERS;
        v    = (slot < NUM_FRAME_INPUTS) ? frames[slot] : 0;
        if (v != 0 && v != delivered_num[slot]) begin
          lead = (v + SEQ_MOD - best) % SEQ_MOD;
          if (!found || (newest_mode && lead > 0 && lead <= AHEAD_MAX)) begin
            found = 1'b1;
            pick  = slot;
            best  = v;
          end
        end
      end
      held_ok = found;
      if (found) begin
        held_slot = pick;
        held_num  = 8'(best);
        r.code    = OC_CHOSEN;
        r.slot    = 2'(pick);
        r.number  = 8'(best);
      end else begin
        r.code = OC_NONE_READY;
      end
    end else if (held_ok) begin
      // The recheck is looked at before the copy flag.
      held_ok  = 1'b0;
      r.slot   = 2'(held_slot);
      r.number = held_num;
      if (recheck != held_num) begin
        r.code = OC_OVERWRITE;
      end else if (!done) begin
        r.code = OC_COPY_FAULT;
      end else begin
        delivered_num[held_slot] = held_num;
        start_slot               = (held_slot + 1) % NUM_BUFFERS;
        r.code                   = OC_DELIVERED;
      end
    end
    return r;
  endfunction

  // Watch the three channels at every edge.
  always @(posedge clk) begin : watch_channels
    selection_t got;
    selection_t want;
    if (rst) begin
      foreach (delivered_num[i]) begin
        delivered_num[i] = '0;
      end
      start_slot  = 0;
      held_slot   = 0;
      held_num    = '0;
      held_ok     = 1'b0;
      newest_mode = 1'b1;
      expected_q.delete();
    end else begin
      // The user must write the register only while the block is idle; the block does not enforce it.
      if (cfg_valid && cfg_ready) begin
        newest_mode = prefer_newest;
      end
      // A result is matched against the oldest prediction.
      if (out_valid && !out_stall) begin
        got.code   = outcome;
        got.slot   = chosen_slot;
        got.number = chosen_number;
        if (expected_q.size() == 0) begin
          flag($sformatf("unexpected result: outcome %0d slot %0d number %0d",
                         got.code, got.slot, got.number));
        end else begin
          want = expected_q.pop_front();
          if (got.code !== want.code || got.slot !== want.slot ||
              got.number !== want.number) begin
            flag($sformatf({"result mismatch: expected outcome %0d slot %0d number %0d,",
                            " got outcome %0d slot %0d number %0d"},
                           want.code, want.slot, want.number,
                           got.code, got.slot, got.number));
          end
        end
      end
      // Every accepted request yields exactly one result.
      if (in_valid && !in_stall) begin
        expected_q.push_back(select_or_settle(
          operation, {frame_number_3, frame_number_2, frame_number_1, frame_number_0},
          recheck_number, copy_done));
      end
    end
    open_count  <= expected_q.size();
    held_number <= held_num;
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the newest frame buffer selector: clock, reset, requests and verdict.
`timescale 1ns / 1ps
module tb_top;
  import nfbs_pkg::*;

  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 230;
  localparam int LONG_HOLD      = 64;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    op_t                                      op;
    logic [NUM_FRAME_INPUTS-1:0][FRAME_W-1:0] frames;
    logic [FRAME_W-1:0]                       recheck;
    logic                                     done;
  } frame_req_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  operation;
  logic [FRAME_W-1:0]    frame_number_0;
  logic [FRAME_W-1:0]    frame_number_1;
  logic [FRAME_W-1:0]    frame_number_2;
  logic [FRAME_W-1:0]    frame_number_3;
  logic [FRAME_W-1:0]    recheck_number;
  logic                  copy_done;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  prefer_newest;
  logic                  out_valid;
  logic                  out_stall;
  logic [OUTCOME_W-1:0]  outcome;
  logic [SLOT_OUT_W-1:0] chosen_slot;
  logic [FRAME_W-1:0]    chosen_number;

  int                    mismatch_count;
  int                    open_count;
  logic [FRAME_W-1:0]    held_number;

  logic                  steady       = 1'b0;
  int                    hold_asked   = 0;
  int                    hold_given   = 0;
  int                    sent         = 0;
  int                    quiet_cycles = 0;

  // Capture buffers as the camera fills them.
  logic [FRAME_W-1:0]    cam_num [NUM_FRAME_INPUTS];
  logic [FRAME_W-1:0]    cam_seq;
  int                    cam_wr;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  newest_frame_buffer_selector dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .frame_number_0 (frame_number_0),
    .frame_number_1 (frame_number_1),
    .frame_number_2 (frame_number_2),
    .frame_number_3 (frame_number_3),
    .recheck_number (recheck_number),
    .copy_done      (copy_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .prefer_newest  (prefer_newest),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .outcome        (outcome),
    .chosen_slot    (chosen_slot),
    .chosen_number  (chosen_number)
  );

  frame_selector_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .frame_number_0 (frame_number_0),
    .frame_number_1 (frame_number_1),
    .frame_number_2 (frame_number_2),
    .frame_number_3 (frame_number_3),
    .recheck_number (recheck_number),
    .copy_done      (copy_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .prefer_newest  (prefer_newest),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .outcome        (outcome),
    .chosen_slot    (chosen_slot),
    .chosen_number  (chosen_number),
    .mismatch_count (mismatch_count),
    .open_count     (open_count),
    .held_number    (held_number)
  );

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Offers one request and holds it until the block takes it.
  task automatic present(frame_req_t r);
    in_valid       <= 1'b1;
    operation      <= r.op;
    frame_number_0 <= r.frames[0];
    frame_number_1 <= r.frames[1];
    frame_number_2 <= r.frames[2];
    frame_number_3 <= r.frames[3];
    recheck_number <= r.recheck;
    copy_done      <= r.done;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent++;
  endtask

  task automatic send_fixed(op_t op, logic [FRAME_W-1:0] f0, f1, f2, f3, rc, logic cd);
    frame_req_t r;
    r.op      = op;
    r.frames  = {f3, f2, f1, f0};
    r.recheck = rc;
    r.done    = cd;
    idle_for(draw_gap());
    present(r);
  endtask

  // Stops offering requests until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
  endtask

  task automatic write_mode(logic newest);
    cfg_valid     <= 1'b1;
    prefer_newest <= newest;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  // The camera writes zero to three more frames into the buffers.
  task automatic camera_advance();
    int writes;
    writes = $urandom_range(0, 3);
    repeat (writes) begin
      // Now and then the sequence jumps far ahead, so leads past half the range occur.
      if ($urandom_range(0, 15) == 0) begin
        cam_seq = 8'($urandom_range(1, 255));
      end
      cam_seq         = (cam_seq == SEQ_MOD) ? 8'd1 : cam_seq + 8'd1;
      cam_num[cam_wr] = ($urandom_range(0, 7) == 0) ? 8'd0 : cam_seq;
      cam_wr          = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3)
                                                    : (cam_wr + 1) % NUM_FRAME_INPUTS;
    end
  endtask

  // Mostly a scan followed by the outcome of its copy; some lone scans and noise.
  task automatic random_item();
    frame_req_t r;
    int         kind;
    int         gap;
    int         pick;
    kind      = $urandom_range(0, 9);
    r.op      = OP_SCAN;
    r.frames  = $urandom;
    r.recheck = 8'($urandom);
    r.done    = 1'($urandom);
    if (kind == 0) begin
      r.op = op_t'($urandom_range(0, 1));
      idle_for(draw_gap());
      present(r);
    end else begin
      camera_advance();
      r.frames = {cam_num[3], cam_num[2], cam_num[1], cam_num[0]};
      idle_for(draw_gap());
      present(r);
      if (kind != 1) begin
        // Wait so the predicted choice is visible; the block is busy scanning anyway.
        gap = draw_gap();
        idle_for((gap == 0) ? 1 : gap);
        pick      = $urandom_range(0, 9);
        r.op      = OP_OUTCOME;
        r.frames  = $urandom;
        r.recheck = (pick == 0) ? held_number ^ 8'($urandom_range(1, 255)) : held_number;
        r.done    = (pick == 1) ? 1'b0 : 1'b1;
        present(r);
      end
    end
  endtask

  // Result side: random stalls per result, and a long hold-off when asked.
  initial begin : result_sink
    int n;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_given != hold_asked) begin
        hold_given++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        n = steady ? 0 : $urandom_range(0, 7);
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Ends the run when no request, result or register write moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_end;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    operation      <= OP_SCAN;
    frame_number_0 <= '0;
    frame_number_1 <= '0;
    frame_number_2 <= '0;
    frame_number_3 <= '0;
    recheck_number <= '0;
    copy_done      <= 1'b0;
    cfg_valid      <= 1'b0;
    prefer_newest  <= 1'b1;
    foreach (cam_num[i]) begin
      cam_num[i] = '0;
    end
    cam_seq = '0;
    cam_wr  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Newest mode after reset: empty history, every outcome and the wrap of the sequence.
    send_fixed(OP_OUTCOME, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1);     // nothing pending
    send_fixed(OP_SCAN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);          // none ready
    send_fixed(OP_SCAN, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1); // equal numbers
    send_fixed(OP_OUTCOME, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 1'b1); // overwritten
    send_fixed(OP_SCAN, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 1'b0);
    send_fixed(OP_OUTCOME, 8'd0, 8'd0, 8'd0, 8'd0, 8'd4, 1'b0);       // copy fault
    send_fixed(OP_SCAN, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 1'b0);
    send_fixed(OP_OUTCOME, 8'd0, 8'd0, 8'd0, 8'd0, 8'd4, 1'b1);       // delivered
    send_fixed(OP_SCAN, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 1'b0);          // delivered one skipped
    send_fixed(OP_OUTCOME, 8'd0, 8'd0, 8'd0, 8'd0, 8'd3, 1'b1);
    send_fixed(OP_SCAN, 8'd254, 8'd255, 8'd1, 8'd0, 8'd0, 1'b0);      // wrap past 255
    send_fixed(OP_SCAN, 8'd200, 8'd72, 8'd0, 8'd0, 8'd0, 1'b0);       // lead of exactly 127
    send_fixed(OP_SCAN, 8'd200, 8'd73, 8'd0, 8'd0, 8'd0, 1'b0);       // lead of 128 loses
    send_fixed(OP_SCAN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);          // drops the pending one
    send_fixed(OP_OUTCOME, 8'd0, 8'd0, 8'd0, 8'd0, 8'd200, 1'b1);     // nothing pending
    send_fixed(OP_SCAN, 8'd0, 8'd0, 8'd3, 8'd4, 8'd0, 1'b0);          // all already delivered

    // First-found mode.
    drain();
    write_mode(1'b0);
    send_fixed(OP_SCAN, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 1'b0);
    send_fixed(OP_OUTCOME, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 1'b1);
    send_fixed(OP_SCAN, 8'd10, 8'd20, 8'd30, 8'd40, 8'd0, 1'b0);
    send_fixed(OP_OUTCOME, 8'd0, 8'd0, 8'd0, 8'd0, 8'd20, 1'b0);

    // Random phases alternate the mode; one runs without idling, two hold results off.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      steady <= (p == 1);
      write_mode(p % 2 == 0);
      if (p == 2 || p == 4) begin
        hold_asked <= hold_asked + 1;
      end
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        random_item();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && open_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
